>>> design/fuap_pkg.sv
package fuap_pkg;

    localparam int BLOCKS            = 4;
    localparam int FIRST_BLOCK_UNITS = 256;
    localparam int TOTAL_UNITS       = FIRST_BLOCK_UNITS * ((1 << BLOCKS) - 1);
    localparam int MAX_BLOCK_UNITS   = FIRST_BLOCK_UNITS << (BLOCKS - 1);

    // Unit index width is fixed by the word format.
    localparam int UNIT_W = 12;
    localparam int EXT_W  = UNIT_W + 1;
    localparam int ADDR_W = (TOTAL_UNITS > 1) ? $clog2(TOTAL_UNITS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCK_UNITS + 1);
    localparam int BLK_W  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int ACT_W  = $clog2(BLOCKS + 1);

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_BLOCK   = 2'd1,
        ST_NO_OWNER   = 2'd2,
        ST_STACK_FULL = 2'd3
    } t_status;

    typedef struct packed {
        logic              cmd;
        logic [UNIT_W-1:0] unit_index;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [UNIT_W-1:0] granted_unit;
        t_status           status;
    } t_resp;

    // Controller to datapath commands.
    typedef struct packed {
        logic load_req;
        logic decide;
        logic load_out;
    } t_dp_cmd;

    function automatic logic [EXT_W-1:0] block_base(input int b);
        return EXT_W'(FIRST_BLOCK_UNITS * ((1 << b) - 1));
    endfunction

    function automatic logic [CNT_W-1:0] block_units(input int b);
        return CNT_W'(FIRST_BLOCK_UNITS << b);
    endfunction

endpackage

>>> design/fixed_unit_pool_allocator.sv
// Fixed-size unit pool allocator.
// Input channel: i_in_valid / o_in_stall carry a request word: cmd selects
// allocate or free, unit_index names the unit to free. Output channel:
// o_out_valid / i_out_stall carry one response word per request: ok,
// granted_unit (zero unless an allocation succeeded) and status.
// A request is loaded into the request register as it enters; then the
// block search, the counter update and the free-stack access happen, and
// then the response loads into the output register. A new request enters
// on the edge at which the previous response loads; the block takes no
// new request until the previous response has loaded.
// When the receiver stalls, the response holds in the output register, one
// further request may enter and finish its search, and then the input
// stalls until the output register frees.
// Reset (synchronous, active low) leaves one block active with empty stacks
// and bump offsets at zero; it takes effect with no clearing pass, since a
// stack entry is only read after it was pushed.
module fixed_unit_pool_allocator
    import fuap_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_req  i_in_word,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    output t_resp o_out_word
);

    t_dp_cmd dp_cmd;

    fuap_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd)
    );

    fuap_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (dp_cmd),
        .i_req   (i_in_word),
        .o_resp  (o_out_word)
    );

endmodule

>>> design/fuap_datapath.sv
module fuap_datapath
    import fuap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_dp_cmd i_cmd,
    input  t_req    i_req,
    output t_resp   o_resp
);

    t_req              r_req;
    logic [ACT_W-1:0]  r_act, n_act;
    logic [CNT_W-1:0]  r_bump  [BLOCKS];
    logic [CNT_W-1:0]  n_bump  [BLOCKS];
    logic [CNT_W-1:0]  r_depth [BLOCKS];
    logic [CNT_W-1:0]  n_depth [BLOCKS];
    logic [UNIT_W-1:0] r_stack [TOTAL_UNITS];
    logic [UNIT_W-1:0] r_rd;
    logic              r_res_ok, r_res_pop;
    logic [UNIT_W-1:0] r_res_unit;
    t_status           r_res_status;
    t_resp             r_out;

    logic              full   [BLOCKS];
    logic              owns   [BLOCKS];
    logic              hit;
    logic [BLK_W-1:0]  sel;
    logic [EXT_W-1:0]  sel_base;
    logic [CNT_W-1:0]  sel_units, sel_bump, sel_depth;
    logic              res_ok, res_pop;
    logic [UNIT_W-1:0] res_unit;
    t_status           res_status;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] mem_addr;

    always_comb begin
        for (int b = 0; b < BLOCKS; b++) begin
            full[b] = (r_bump[b] >= block_units(b)) && (r_depth[b] == '0);
            owns[b] = (ACT_W'(b) < r_act)
                && ({1'b0, r_req.unit_index} >= block_base(b))
                && ({1'b0, r_req.unit_index} < block_base(b) + EXT_W'(block_units(b)));
        end
    end

    // Block selection: first non-full active block on allocate, owner on free.
    always_comb begin
        hit = 1'b0;
        sel = '0;
        for (int b = 0; b < BLOCKS; b++) begin
            if (!hit) begin
                if (r_req.cmd == CMD_ALLOC) begin
                    if ((ACT_W'(b) < r_act) && !full[b]) begin
                        hit = 1'b1;
                        sel = BLK_W'(b);
                    end
                end else if (owns[b]) begin
                    hit = 1'b1;
                    sel = BLK_W'(b);
                end
            end
        end
        // Every active block is full: the next one is fresh, so it bumps.
        if (!hit && r_req.cmd == CMD_ALLOC && r_act < ACT_W'(BLOCKS)) begin
            sel = BLK_W'(r_act);
        end
    end

    always_comb begin
        sel_base  = '0;
        sel_units = '0;
        for (int b = 0; b < BLOCKS; b++) begin
            if (sel == BLK_W'(b)) begin
                sel_base  = block_base(b);
                sel_units = block_units(b);
            end
        end
        sel_bump  = r_bump[sel];
        sel_depth = r_depth[sel];
    end

    always_comb begin
        n_act      = r_act;
        n_bump     = r_bump;
        n_depth    = r_depth;
        res_ok     = 1'b0;
        res_pop    = 1'b0;
        res_unit   = '0;
        res_status = ST_OK;
        wr_en      = 1'b0;
        rd_en      = 1'b0;
        mem_addr   = '0;
        if (r_req.cmd == CMD_ALLOC) begin
            if (!hit && r_act >= ACT_W'(BLOCKS)) begin
                res_status = ST_NO_BLOCK;
            end else begin
                res_ok = 1'b1;
                if (!hit) begin
                    n_act = r_act + 1'b1;
                end
                if (hit && sel_depth != '0) begin
                    res_pop      = 1'b1;
                    rd_en        = 1'b1;
                    n_depth[sel] = sel_depth - 1'b1;
                    mem_addr     = ADDR_W'(sel_base + EXT_W'(sel_depth) - 1'b1);
                end else begin
                    res_unit    = UNIT_W'(sel_base + EXT_W'(sel_bump));
                    n_bump[sel] = sel_bump + 1'b1;
                end
            end
        end else begin
            if (!hit) begin
                res_status = ST_NO_OWNER;
            end else if (sel_depth >= sel_units) begin
                res_status = ST_STACK_FULL;
            end else begin
                res_ok       = 1'b1;
                wr_en        = 1'b1;
                n_depth[sel] = sel_depth + 1'b1;
                mem_addr     = ADDR_W'(sel_base + EXT_W'(sel_depth));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= ACT_W'(1);
            for (int b = 0; b < BLOCKS; b++) begin
                r_bump[b]  <= '0;
                r_depth[b] <= '0;
            end
        end else if (i_cmd.decide) begin
            r_act   <= n_act;
            r_bump  <= n_bump;
            r_depth <= n_depth;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide && wr_en) begin
            r_stack[mem_addr] <= r_req.unit_index;
        end
        if (i_cmd.decide && rd_en) begin
            r_rd <= r_stack[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req;
        end
        if (i_cmd.decide) begin
            r_res_ok     <= res_ok;
            r_res_pop    <= res_pop;
            r_res_unit   <= res_unit;
            r_res_status <= res_status;
        end
        if (i_cmd.load_out) begin
            r_out.ok           <= r_res_ok;
            r_out.granted_unit <= r_res_pop ? r_rd : r_res_unit;
            r_out.status       <= r_res_status;
        end
    end

    assign o_resp = r_out;

endmodule

>>> design/fuap_ctrl.sv
module fuap_ctrl
    import fuap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_EMIT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free, accept, load_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign load_out   = (r_state == S_EMIT) && out_free;
    // A new word may enter while the previous result is being loaded out.
    assign o_in_stall = !((r_state == S_IDLE) || load_out);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (accept) n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT: begin
                if (load_out) begin
                    n_state = accept ? S_DECIDE : S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
        n_out_valid = load_out || (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_cmd.load_req = accept;
    assign o_cmd.decide   = (r_state == S_DECIDE);
    assign o_cmd.load_out = load_out;

endmodule

>>> design/fuap_checker.sv
module fuap_checker
    import fuap_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  i_in_valid,
    input logic  o_in_stall,
    input t_req  i_in_word,
    input logic  o_out_valid,
    input logic  i_out_stall,
    input t_resp o_out_word
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("response word changed while stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.ok == (o_out_word.status == ST_OK)))
        else $error("ok flag disagrees with status");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.ok |-> o_out_word.granted_unit == '0)
        else $error("failed request carries a unit");

    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("request word changed while stalled");

endmodule

bind fixed_unit_pool_allocator fuap_checker u_fuap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

>>> verif/tb.sv
module tb;
    import fuap_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int MAX_WAIT    = 18;
    localparam int FILL_ITEMS  = 300;
    localparam int CHUNKS      = 4;
    localparam int CHUNK_ITEMS = 45;

    logic  i_clk       = 1'b0;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    t_req  i_in_word   = '0;
    logic  i_out_stall = 1'b0;
    logic  o_in_stall;
    logic  o_out_valid;
    t_resp o_out_word;

    fixed_unit_pool_allocator DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Shadow copy of the allocator state.
    int               live_blocks;
    int               bump_cnt  [BLOCKS];
    int               depth_cnt [BLOCKS];
    logic [UNIT_W-1:0] stack_mem [TOTAL_UNITS];

    t_req              request_q  [$];
    t_resp             response_q [$];
    logic [UNIT_W-1:0] held_units [$];

    bit    idle_on;
    int    errors;
    int    cycles;
    t_req  cur_req;
    bit    presenting;
    int    gap_left;
    int    stall_left;
    t_resp want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int first_unit(int b);
        return FIRST_BLOCK_UNITS * ((1 << b) - 1);
    endfunction

    function automatic int unit_count(int b);
        return FIRST_BLOCK_UNITS << b;
    endfunction

    // Caller makes sure block b still has a unit to give.
    function automatic int pop_or_bump(int b);
        int unit;
        if (depth_cnt[b] > 0) begin
            depth_cnt[b]--;
            unit = int'(stack_mem[first_unit(b) + depth_cnt[b]]);
        end else begin
            unit = first_unit(b) + bump_cnt[b];
            bump_cnt[b]++;
        end
        return unit;
    endfunction

    function automatic t_resp allocator_response(t_req req);
        t_resp rsp;
        int    idx;
        int    slot;
        bit    done;
        rsp = '0;
        rsp.status = ST_OK;
        done = 1'b0;
        if (req.cmd == CMD_ALLOC) begin
            for (int b = 0; b < live_blocks && !done; b++) begin
                if (bump_cnt[b] < unit_count(b) || depth_cnt[b] > 0) begin
                    rsp.granted_unit = UNIT_W'(pop_or_bump(b));
                    done = 1'b1;
                end
            end
            if (!done && live_blocks < BLOCKS) begin
                live_blocks++;
                rsp.granted_unit = UNIT_W'(pop_or_bump(live_blocks - 1));
                done = 1'b1;
            end
            if (done) begin
                rsp.ok = 1'b1;
                held_units.push_back(rsp.granted_unit);
            end else begin
                rsp.status = ST_NO_BLOCK;
            end
        end else begin
            idx = int'(req.unit_index);
            rsp.status = ST_NO_OWNER;
            for (int b = 0; b < live_blocks && !done; b++) begin
                if (idx >= first_unit(b) && idx < first_unit(b) + unit_count(b)) begin
                    done = 1'b1;
                    if (depth_cnt[b] >= unit_count(b)) begin
                        rsp.status = ST_STACK_FULL;
                    end else begin
                        slot = first_unit(b) + depth_cnt[b];
                        stack_mem[slot] = req.unit_index;
                        depth_cnt[b]++;
                        rsp.ok = 1'b1;
                        rsp.status = ST_OK;
                    end
                end
            end
        end
        return rsp;
    endfunction

    function automatic t_req make_req(logic cmd, int idx);
        t_req req;
        req.cmd        = cmd;
        req.unit_index = UNIT_W'(idx);
        return req;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= 100) begin
            $display("mismatch at cycle %0d: %s", cycles, what);
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_q.size() > 0 || presenting || response_q.size() > 0);
    endtask

    // Request driver: while idle_on is set, each word after an accepted one waits a random gap before it is offered.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            presenting = 1'b0;
            gap_left   = 0;
            i_in_valid <= 1'b0;
            i_in_word  <= '0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                response_q.push_back(allocator_response(i_in_word));
                presenting = 1'b0;
                gap_left   = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end
            if (!presenting) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() > 0) begin
                    cur_req    = request_q.pop_front();
                    presenting = 1'b1;
                end
            end
            i_in_valid <= presenting;
            i_in_word  <= cur_req;
        end
    end

    // Response monitor with random receiver stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                if (response_q.size() == 0) begin
                    report_mismatch($sformatf("response word %h with none pending", o_out_word));
                end else begin
                    want = response_q.pop_front();
                    if (o_out_word.ok !== want.ok) begin
                        report_mismatch($sformatf("ok %b, want %b", o_out_word.ok, want.ok));
                    end
                    if (o_out_word.granted_unit !== want.granted_unit) begin
                        report_mismatch($sformatf("granted_unit %0d, want %0d",
                                                  o_out_word.granted_unit, want.granted_unit));
                    end
                    if (o_out_word.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  o_out_word.status, want.status));
                    end
                end
                stall_left = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            i_out_stall <= (stall_left > 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("fixed_unit_pool_allocator verification failed");
            $finish;
        end
    end

    initial begin
        int r;
        int k;
        errors      = 0;
        cycles      = 0;
        idle_on     = 1'b1;
        live_blocks = 1;
        for (int b = 0; b < BLOCKS; b++) begin
            bump_cnt[b]  = 0;
            depth_cnt[b] = 0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words with only the first block active.
        request_q.push_back(make_req(CMD_ALLOC, 0));
        request_q.push_back(make_req(CMD_ALLOC, 0));
        request_q.push_back(make_req(CMD_FREE, 0));
        request_q.push_back(make_req(CMD_ALLOC, 0));
        request_q.push_back(make_req(CMD_FREE, 4095));
        request_q.push_back(make_req(CMD_FREE, 256));
        request_q.push_back(make_req(CMD_FREE, TOTAL_UNITS - 1));
        request_q.push_back(make_req(CMD_FREE, 1));
        request_q.push_back(make_req(CMD_FREE, 1));
        request_q.push_back(make_req(CMD_ALLOC, 0));
        request_q.push_back(make_req(CMD_ALLOC, 0));
        request_q.push_back(make_req(CMD_FREE, 255));
        request_q.push_back(make_req(CMD_ALLOC, 4095));
        request_q.push_back(make_req(CMD_ALLOC, 4095));
        request_q.push_back(make_req(CMD_FREE, 2));
        wait_idle();

        // Allocate back to back until the first block is used up and the second is active.
        idle_on = 1'b0;
        for (int i = 0; i < FILL_ITEMS; i++) begin
            request_q.push_back(make_req(CMD_ALLOC, $urandom_range(0, 4095)));
        end
        wait_idle();

        // Overfill the first block's free stack.
        idle_on = 1'b1;
        for (int i = 0; i < FIRST_BLOCK_UNITS + 2; i++) begin
            request_q.push_back(make_req(CMD_FREE, $urandom_range(0, FIRST_BLOCK_UNITS - 1)));
        end
        wait_idle();

        // Random traffic: allocations mixed with frees of granted units and of random indices.
        for (int c = 0; c < CHUNKS; c++) begin
            idle_on = ($urandom_range(0, 3) != 0);
            for (int i = 0; i < CHUNK_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    request_q.push_back(make_req(CMD_ALLOC, $urandom_range(0, 4095)));
                end else if (r < 80 && held_units.size() > 0) begin
                    k = $urandom_range(0, held_units.size() - 1);
                    request_q.push_back(make_req(CMD_FREE, held_units[k]));
                    held_units.delete(k);
                end else if (r < 90) begin
                    request_q.push_back(make_req(CMD_FREE, $urandom_range(0, TOTAL_UNITS - 1)));
                end else begin
                    request_q.push_back(make_req(CMD_FREE, $urandom_range(0, 4095)));
                end
            end
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("fixed_unit_pool_allocator verification clean");
        end else begin
            $display("fixed_unit_pool_allocator verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
design/fuap_pkg.sv
design/fuap_datapath.sv
design/fuap_ctrl.sv
design/fixed_unit_pool_allocator.sv
design/fuap_checker.sv
verif/tb.sv
